### rtl/bgb_pkg.sv
package bgb_pkg;

  // Default geometry of the font and the glyph store.
  localparam int DEF_GLYPH_HEIGHT = 16;
  localparam int DEF_GLYPH_WIDTH  = 8;
  localparam int DEF_MAX_GLYPHS   = 256;

  // Fixed field widths of the command and result ports.
  localparam int CODE_W   = 8;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 8;
  localparam int COLOR_W  = 32;
  localparam int LROW_W   = 4;
  localparam int BITS_W   = 8;
  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 64;
  localparam int PITCH_W  = 16;
  localparam int COUNT_W  = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [ADDR_W-1:0]  RST_FRAME_BASE  = '0;
  localparam logic [PITCH_W-1:0] RST_LINE_PITCH  = 16'd4096;
  localparam logic [COUNT_W-1:0] RST_GLYPH_COUNT = 9'd256;

  // Command codes carried on the command input.
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_BASE  = 2'd0,
    CFG_LINE_PITCH  = 2'd1,
    CFG_GLYPH_COUNT = 2'd2
  } cfg_index_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load;
    logic mult;
    logic sum;
    logic emit;
    logic row_end;
    logic last;
  } dp_cmd_t;

endpackage

### rtl/bgb_ctrl.sv
module bgb_ctrl
  import bgb_pkg::*;
#(
  parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT,
  parameter int GLYPH_WIDTH  = DEF_GLYPH_WIDTH,
  localparam int PAIRS = (GLYPH_WIDTH + 1) / 2,
  localparam int RC_W  = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1,
  localparam int PC_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            command,
  output logic            busy,
  output dp_cmd_t         cmd,
  output logic [RC_W-1:0] rd_row,
  output logic [PC_W-1:0] pair
);

  state_t          state, state_next;
  logic [RC_W-1:0] row_cnt, row_cnt_next;
  logic [PC_W-1:0] pair_cnt, pair_cnt_next;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      row_cnt  <= '0;
      pair_cnt <= '0;
    end else begin
      state    <= state_next;
      row_cnt  <= row_cnt_next;
      pair_cnt <= pair_cnt_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    row_cnt_next  = row_cnt;
    pair_cnt_next = pair_cnt;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (command == CMD_DRAW) begin
            cmd.capture = 1'b1;
            state_next  = ST_MUL;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.mult   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit      = 1'b1;
        pair_cnt_next = pair_cnt + 1'b1;
        if (pair_cnt == PC_W'(PAIRS - 1)) begin
          pair_cnt_next = '0;
          cmd.row_end   = 1'b1;
          row_cnt_next  = row_cnt + 1'b1;
          if (row_cnt == RC_W'(GLYPH_HEIGHT - 1)) begin
            cmd.last     = 1'b1;
            row_cnt_next = '0;
            state_next   = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The store read is registered, so it is addressed by the coming row.
  assign rd_row = row_cnt_next;
  assign pair   = pair_cnt;
  assign busy   = (state != ST_IDLE);

endmodule

### rtl/bgb_datapath.sv
module bgb_datapath
  import bgb_pkg::*;
#(
  parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT,
  parameter int GLYPH_WIDTH  = DEF_GLYPH_WIDTH,
  parameter int MAX_GLYPHS   = DEF_MAX_GLYPHS,
  localparam int PAIRS = (GLYPH_WIDTH + 1) / 2,
  localparam int RC_W  = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1,
  localparam int PC_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  input  logic [RC_W-1:0]       rd_row,
  input  logic [PC_W-1:0]       pair,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CODE_W-1:0]     char_code,
  input  logic [COL_W-1:0]      cell_col,
  input  logic [ROW_W-1:0]      cell_row,
  input  logic [COLOR_W-1:0]    fg_color,
  input  logic [COLOR_W-1:0]    bg_color,
  input  logic [LROW_W-1:0]     load_row,
  input  logic [BITS_W-1:0]     load_bits,
  output logic [ADDR_W-1:0]     write_addr,
  output logic [DATA_W-1:0]     write_data,
  output logic                  last_write,
  output logic                  write_strobe
);

  localparam int DEPTH = MAX_GLYPHS * GLYPH_HEIGHT;
  localparam int SA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GI_W  = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int GH_LOG = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 0;
  localparam int GW_LOG = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 0;
  localparam int Y_W   = ROW_W + GH_LOG;
  localparam int X_W   = COL_W + GW_LOG + 2;
  localparam int P_W   = PITCH_W + Y_W;
  localparam int PX_W  = PC_W + 1;

  // Configuration registers.
  logic [ADDR_W-1:0]  frame_base;
  logic [PITCH_W-1:0] line_pitch;
  logic [COUNT_W-1:0] glyph_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base  <= RST_FRAME_BASE;
      line_pitch  <= RST_LINE_PITCH;
      glyph_count <= RST_GLYPH_COUNT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_BASE:  frame_base  <= cfg_data;
        CFG_LINE_PITCH:  line_pitch  <= cfg_data[PITCH_W-1:0];
        CFG_GLYPH_COUNT: glyph_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Glyph store: one write port for loads, one registered read port.
  logic [BITS_W-1:0] glyph_store [DEPTH];
  logic [BITS_W-1:0] rd_data;
  logic [SA_W-1:0]   glyph_base;
  logic [SA_W-1:0]   wr_addr;
  logic              wr_ok;

  assign wr_ok = (32'(char_code) < MAX_GLYPHS) && (32'(load_row) < GLYPH_HEIGHT);
  assign wr_addr = SA_W'(char_code) * SA_W'(GLYPH_HEIGHT) + SA_W'(load_row);

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      glyph_store[wr_addr] <= load_bits;
    end
    rd_data <= glyph_store[glyph_base + SA_W'(rd_row)];
  end

  // Glyph selection with fallback to glyph 0.
  logic            code_ok;
  logic [GI_W-1:0] glyph_sel;

  assign code_ok = (char_code != '0) && (COUNT_W'(char_code) < glyph_count) &&
                   (32'(char_code) < MAX_GLYPHS);
  assign glyph_sel = code_ok ? GI_W'(char_code) : '0;

  // Transaction capture and the address setup sequence.
  logic [COLOR_W-1:0] fg, bg;
  logic [Y_W-1:0]     y0;
  logic [X_W-1:0]     xbyte;
  logic [P_W-1:0]     prod;
  logic [ADDR_W-1:0]  line_addr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fg         <= fg_color;
      bg         <= bg_color;
      glyph_base <= SA_W'(glyph_sel) * SA_W'(GLYPH_HEIGHT);
      y0         <= Y_W'(cell_row) * Y_W'(GLYPH_HEIGHT);
      xbyte      <= X_W'(cell_col) * X_W'(GLYPH_WIDTH * 4);
    end
    if (cmd.mult) begin
      prod <= P_W'(line_pitch) * P_W'(y0);
    end
    if (cmd.sum) begin
      line_addr <= frame_base + ADDR_W'(prod) + ADDR_W'(xbyte);
    end else if (cmd.row_end) begin
      line_addr <= line_addr + ADDR_W'(line_pitch);
    end
  end

  // Pixel pair selection from the current glyph row.
  logic [PX_W-1:0]   px;
  logic [BITS_W-1:0] shifted;
  logic              hi_inside;
  logic [COLOR_W-1:0] pix_lo, pix_hi;

  assign px        = {pair, 1'b0};
  assign shifted   = rd_data << px;
  assign hi_inside = (32'(px) + 1) < GLYPH_WIDTH;
  assign pix_lo    = shifted[GLYPH_WIDTH-1] ? fg : bg;
  assign pix_hi    = (hi_inside && shifted[GLYPH_WIDTH-2]) ? fg : bg;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_strobe <= 1'b0;
      last_write   <= 1'b0;
    end else begin
      write_strobe <= cmd.emit;
      last_write   <= cmd.last;
    end
    write_addr <= line_addr + ADDR_W'({pair, 3'b000});
    write_data <= {pix_hi, pix_lo};
  end

endmodule

### rtl/bitmap_glyph_blitter.sv
// Load transaction: busy stays low, no write is produced.
// Draw transaction: MUL and SUM setup states form the cell address, then one pixel-pair
// write per cycle, GLYPH_HEIGHT*ceil(GLYPH_WIDTH/2) writes (64 by default).
// Each write strobe is registered from an EMIT state; a new draw can follow once busy falls.
// The rate is set by the single 64-bit write port; the receiver cannot stall it.
// Synchronous reset clears the controller and configuration; glyph store is not cleared.
module bitmap_glyph_blitter
  import bgb_pkg::*;
#(
  parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT,
  parameter int GLYPH_WIDTH  = DEF_GLYPH_WIDTH,
  parameter int MAX_GLYPHS   = DEF_MAX_GLYPHS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  command,
  input  logic [CODE_W-1:0]     char_code,
  input  logic [COL_W-1:0]      cell_col,
  input  logic [ROW_W-1:0]      cell_row,
  input  logic [COLOR_W-1:0]    fg_color,
  input  logic [COLOR_W-1:0]    bg_color,
  input  logic [LROW_W-1:0]     load_row,
  input  logic [BITS_W-1:0]     load_bits,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  write_strobe,
  output logic [ADDR_W-1:0]     write_addr,
  output logic [DATA_W-1:0]     write_data,
  output logic                  last_write
);

  localparam int PAIRS = (GLYPH_WIDTH + 1) / 2;
  localparam int RC_W  = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam int PC_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  dp_cmd_t         cmd;
  logic [RC_W-1:0] rd_row;
  logic [PC_W-1:0] pair;

  // Configuration writes are taken only when no draw is in progress and no
  // command transaction is being offered, so a command never sees a half-applied
  // configuration.
  assign cfg_ready = !busy && !start;

  bgb_ctrl #(
    .GLYPH_HEIGHT(GLYPH_HEIGHT),
    .GLYPH_WIDTH (GLYPH_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .busy   (busy),
    .cmd    (cmd),
    .rd_row (rd_row),
    .pair   (pair)
  );

  bgb_datapath #(
    .GLYPH_HEIGHT(GLYPH_HEIGHT),
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .MAX_GLYPHS  (MAX_GLYPHS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_row      (rd_row),
    .pair        (pair),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .char_code   (char_code),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .fg_color    (fg_color),
    .bg_color    (bg_color),
    .load_row    (load_row),
    .load_bits   (load_bits),
    .write_addr  (write_addr),
    .write_data  (write_data),
    .last_write  (last_write),
    .write_strobe(write_strobe)
  );

  // A draw ends exactly when its final write is presented.
  assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (write_strobe && last_write))
    else $error("draw ended without its final write");

  // Writes come only out of a draw in progress.
  assert property (@(posedge clk) disable iff (rst)
    write_strobe |-> $past(busy))
    else $error("write strobe outside a draw");

  // The final-write flag never stands alone.
  assert property (@(posedge clk) disable iff (rst)
    last_write |-> write_strobe)
    else $error("final-write flag without a write");

  // A load transaction never starts a draw.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == CMD_LOAD)) |=> !busy)
    else $error("load transaction made the block busy");

endmodule

### tb/bitmap_glyph_blitter_test.sv
module bitmap_glyph_blitter_test;
  import bgb_pkg::*;

  localparam int GLYPH_H  = DEF_GLYPH_HEIGHT;
  localparam int GLYPH_W  = DEF_GLYPH_WIDTH;
  localparam int GLYPHS   = DEF_MAX_GLYPHS;
  localparam int PAIRS    = (GLYPH_W + 1) / 2;
  localparam int STALL_LIMIT = 2000;

  // One command transaction as presented on the input ports.
  typedef struct {
    logic               command;
    logic [CODE_W-1:0]  code;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [LROW_W-1:0]  lrow;
    logic [BITS_W-1:0]  lbits;
  } cell_cmd_t;

  // One framebuffer write as expected on the result ports.
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } pixel_write_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  command = CMD_DRAW;
  logic [CODE_W-1:0]     char_code = '0;
  logic [COL_W-1:0]      cell_col = '0;
  logic [ROW_W-1:0]      cell_row = '0;
  logic [COLOR_W-1:0]    fg_color = '0;
  logic [COLOR_W-1:0]    bg_color = '0;
  logic [LROW_W-1:0]     load_row = '0;
  logic [BITS_W-1:0]     load_bits = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_BASE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  write_strobe;
  logic [ADDR_W-1:0]     write_addr;
  logic [DATA_W-1:0]     write_data;
  logic                  last_write;

  bitmap_glyph_blitter dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .char_code    (char_code),
    .cell_col     (cell_col),
    .cell_row     (cell_row),
    .fg_color     (fg_color),
    .bg_color     (bg_color),
    .load_row     (load_row),
    .load_bits    (load_bits),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .write_strobe (write_strobe),
    .write_addr   (write_addr),
    .write_data   (write_data),
    .last_write   (last_write)
  );

  // Pending commands, expected writes and bookkeeping.
  cell_cmd_t    cmd_queue[$];
  cell_cmd_t    next_cmd;
  pixel_write_t pixel_writes_due[$];
  int           queued_count = 0;
  int           accepted_count = 0;
  int           errors = 0;
  int           gap_left = 0;
  int           burst_left = 0;
  int           quiet_cycles = 0;

  // Shadow of the block's configuration and glyph store.
  logic [ADDR_W-1:0]  shadow_base;
  logic [PITCH_W-1:0] shadow_pitch;
  logic [COUNT_W-1:0] shadow_count;
  logic [BITS_W-1:0]  font_rows [GLYPHS*GLYPH_H];

  // Stimulus-side record of which glyph rows have been loaded.
  logic [GLYPH_H-1:0] rows_loaded [GLYPHS];
  int                 drawable_codes[$];
  int                 gen_count;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [COLOR_W-1:0] pixel_of(logic [BITS_W-1:0] bits, int px,
                                                  logic [COLOR_W-1:0] fg,
                                                  logic [COLOR_W-1:0] bg);
    if (px >= GLYPH_W) return bg;
    return bits[GLYPH_W-1-px] ? fg : bg;
  endfunction

  // Expand one draw into its pixel-pair writes, top row first, left to right.
  function automatic void render_cell(logic [CODE_W-1:0] code, logic [COL_W-1:0] col,
                                      logic [ROW_W-1:0] row, logic [COLOR_W-1:0] fg,
                                      logic [COLOR_W-1:0] bg);
    int unsigned  glyph;
    int unsigned  x;
    int unsigned  y;
    int           px;
    logic [BITS_W-1:0] bits;
    pixel_write_t pw;
    glyph = (code != 0 && code < shadow_count && code < GLYPHS) ? 32'(code) : 32'd0;
    for (int r = 0; r < GLYPH_H; r++) begin
      bits = font_rows[glyph*GLYPH_H + r];
      for (int p = 0; p < PAIRS; p++) begin
        px = 2 * p;
        x = col * GLYPH_W + px;
        y = row * GLYPH_H + r;
        pw.addr = shadow_base + shadow_pitch * y + 4 * x;
        pw.data = {pixel_of(bits, px + 1, fg, bg), pixel_of(bits, px, fg, bg)};
        pw.last = (r == GLYPH_H - 1) && (p == PAIRS - 1);
        pixel_writes_due.push_back(pw);
      end
    end
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [BITS_W-1:0] pick_bits();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return BITS_W'($urandom);
    endcase
  endfunction

  function automatic void queue_load(int code, int lrow, logic [BITS_W-1:0] bits);
    cell_cmd_t c;
    c.command = CMD_LOAD;
    c.code = CODE_W'(code);
    c.col = COL_W'($urandom);
    c.row = ROW_W'($urandom);
    c.fg = $urandom;
    c.bg = $urandom;
    c.lrow = LROW_W'(lrow);
    c.lbits = bits;
    cmd_queue.push_back(c);
    queued_count++;
    if (rows_loaded[code] != '1) begin
      rows_loaded[code][lrow] = 1'b1;
      if (rows_loaded[code] == '1) drawable_codes.push_back(code);
    end
  endfunction

  function automatic void queue_draw(int code, logic [COL_W-1:0] col,
                                     logic [ROW_W-1:0] row, logic [COLOR_W-1:0] fg,
                                     logic [COLOR_W-1:0] bg);
    cell_cmd_t c;
    c.command = CMD_DRAW;
    c.code = CODE_W'(code);
    c.col = col;
    c.row = row;
    c.fg = fg;
    c.bg = bg;
    c.lrow = LROW_W'($urandom);
    c.lbits = BITS_W'($urandom);
    cmd_queue.push_back(c);
    queued_count++;
  endfunction

  // A draw may only touch a glyph whose rows are all loaded, or one that falls back.
  function automatic int safe_code(int code);
    if (code == 0 || code >= gen_count || rows_loaded[code] == '1) return code;
    return drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
  endfunction

  task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every command is taken and every write is in, then let the block settle.
  task automatic wait_drained();
    while (accepted_count != queued_count || pixel_writes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Driver: sends commands in bursts separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (!start || !busy) begin
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_queue.size() != 0) begin
        next_cmd = cmd_queue.pop_front();
        start <= 1'b1;
        command <= next_cmd.command;
        char_code <= next_cmd.code;
        cell_col <= next_cmd.col;
        cell_row <= next_cmd.row;
        fg_color <= next_cmd.fg;
        bg_color <= next_cmd.bg;
        load_row <= next_cmd.lrow;
        load_bits <= next_cmd.lbits;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Configuration shadow follows each register write transaction.
  always @(posedge clk) begin
    if (rst) begin
      shadow_base = RST_FRAME_BASE;
      shadow_pitch = RST_LINE_PITCH;
      shadow_count = RST_GLYPH_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_FRAME_BASE:  shadow_base = cfg_data[ADDR_W-1:0];
        CFG_LINE_PITCH:  shadow_pitch = cfg_data[PITCH_W-1:0];
        CFG_GLYPH_COUNT: shadow_count = cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Predictor: each accepted command updates the font or queues its writes.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      if (command == CMD_LOAD) begin
        if (char_code < GLYPHS && load_row < GLYPH_H)
          font_rows[char_code*GLYPH_H + load_row] = load_bits;
      end else begin
        render_cell(char_code, cell_col, cell_row, fg_color, bg_color);
      end
      accepted_count++;
    end
  end

  // Monitor: every strobed write is checked against the oldest expected write.
  always @(posedge clk) begin
    pixel_write_t want;
    if (!rst && write_strobe) begin
      if (pixel_writes_due.size() == 0) begin
        $display("%0t: unexpected write, actual addr %h data %h last %b",
                 $realtime, write_addr, write_data, last_write);
        errors++;
      end else begin
        want = pixel_writes_due.pop_front();
        if (write_addr !== want.addr) begin
          $display("%0t: write_addr mismatch, expected %h, actual %h",
                   $realtime, want.addr, write_addr);
          errors++;
        end
        if (write_data !== want.data) begin
          $display("%0t: write_data mismatch, expected %h, actual %h",
                   $realtime, want.data, write_data);
          errors++;
        end
        if (last_write !== want.last) begin
          $display("%0t: last_write mismatch, expected %b, actual %b",
                   $realtime, want.last, last_write);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || write_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog timeout, no transaction for %0d cycles", $realtime, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed cells first, then phases of random traffic under several settings.
  initial begin
    logic [BITS_W-1:0] edge_rows [GLYPH_H];
    int n;
    int code;
    int sel;
    logic [ADDR_W-1:0]  base_v;
    logic [PITCH_W-1:0] pitch_v;
    int count_v;
    edge_rows = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F,
                  8'hC3, 8'h3C, 8'h81, 8'h7E, 8'h18, 8'hE7, 8'h01, 8'h80};
    foreach (rows_loaded[i]) rows_loaded[i] = '0;
    gen_count = int'(RST_GLYPH_COUNT);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Glyph 0 is the fallback for every out-of-range code, so it is loaded first.
    for (int r = 0; r < GLYPH_H; r++) queue_load(0, r, edge_rows[r]);
    queue_draw(0, '0, '0, '1, '0);
    queue_draw(0, '1, '1, '0, '1);
    queue_load(255, 0, 8'h80);
    for (int r = 1; r < GLYPH_H; r++) queue_load(255, r, edge_rows[GLYPH_H-1-r]);
    queue_draw(255, '1, '0, 32'h1234_5678, 32'h9ABC_DEF0);
    queue_draw(255, '0, '1, 32'hA5A5_A5A5, 32'h5A5A_5A5A);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase != 0) begin
        wait_drained();
        case (phase)
          1: begin base_v = '1; pitch_v = '1; count_v = 1; end
          2: begin base_v = $urandom; pitch_v = '0; count_v = GLYPHS; end
          3: begin base_v = $urandom; pitch_v = PITCH_W'($urandom);
                   count_v = $urandom_range(2, 255); end
          4: begin base_v = 32'hFFFF_F000; pitch_v = 16'd4096;
                   count_v = $urandom_range(1, 64); end
          default: begin base_v = $urandom; pitch_v = PITCH_W'($urandom);
                         count_v = $urandom_range(1, GLYPHS); end
        endcase
        write_register(CFG_FRAME_BASE, base_v);
        write_register(CFG_LINE_PITCH, CFG_DATA_W'(pitch_v));
        write_register(CFG_GLYPH_COUNT, count_v);
        gen_count = count_v;
      end

      n = 0;
      while (n < 68) begin
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          // Full glyph load followed by a draw of that glyph.
          code = $urandom_range(1, GLYPHS - 1);
          for (int r = 0; r < GLYPH_H; r++) queue_load(code, r, pick_bits());
          queue_draw(code, COL_W'($urandom), ROW_W'($urandom), pick_color(), pick_color());
          n += GLYPH_H + 1;
        end else if (sel < 70) begin
          code = ($urandom_range(0, 19) == 0) ? 0 : safe_code($urandom_range(0, GLYPHS - 1));
          queue_draw(code, COL_W'($urandom), ROW_W'($urandom), pick_color(), pick_color());
          n++;
        end else if (sel < 85) begin
          // Overwrite one row of a glyph that is already drawable.
          code = drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
          queue_load(code, $urandom_range(0, GLYPH_H - 1), pick_bits());
          n++;
        end else begin
          // Stray load into any glyph, possibly leaving it partly written.
          queue_load($urandom_range(0, GLYPHS - 1), $urandom_range(0, GLYPH_H - 1),
                     BITS_W'($urandom));
          n++;
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
